// ===== rtl/bt_pkg.sv =====
// Shared types, constants and fixed-point helpers for the backstepping tracker.
// No dependencies; every other file in rtl/ imports this package.
package bt_pkg;

    // Valid stages from an accepted start to done
    localparam int PIPE_DEPTH = 16;
    // Latency of the sine/cosine pipeline, angle register to output register
    localparam int SC_LAT = 7;

    localparam logic signed [63:0] PHASE_SCALE = 64'sd683565276;
    localparam logic signed [32:0] PC1 = 33'sd1686629713;
    localparam logic signed [32:0] PC3 = -33'sd693598667;
    localparam logic signed [32:0] PC5 = 33'sd85569307;
    localparam logic signed [32:0] PC7 = -33'sd5026993;
    localparam logic signed [32:0] PC9 = 33'sd172272;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [30:0] GAIN_RESET = 31'd65536;

    localparam logic signed [47:0] Q_MAX48 = 48'sd2147483647;
    localparam logic signed [47:0] Q_MIN48 = -48'sd2147483648;

    // Configuration register indexes
    localparam logic [7:0] REG_GAIN_LONG = 8'd0;
    localparam logic [7:0] REG_GAIN_LAT  = 8'd1;
    localparam logic [7:0] REG_GAIN_HEAD = 8'd2;
    localparam logic [7:0] REG_GAIN_VEL  = 8'd3;

    typedef struct packed {
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        logic signed [31:0] cur_heading;
        logic signed [31:0] cur_lin_speed;
        logic signed [31:0] cur_ang_speed;
        logic signed [31:0] ref_x;
        logic signed [31:0] ref_y;
        logic signed [31:0] ref_heading;
        logic signed [31:0] ref_lin_speed;
        logic signed [31:0] ref_ang_speed;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] lin_drive;
        logic signed [31:0] ang_drive;
    } result_t;

    typedef struct packed {
        logic [30:0] k1;
        logic [30:0] k2;
        logic [30:0] k3;
        logic [30:0] k4;
    } gains_t;

    // Saturate a wide signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > Q_MAX48)
            r = 32'sh7fffffff;
        else if (v < Q_MIN48)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Q16.16 multiply: exact product, floor shift by 16, saturate
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat32(p[63:16]);
    endfunction

    // Gain register seen as a non-negative Q16.16 value
    function automatic logic signed [31:0] gain_q(input logic [30:0] k);
        return signed'({1'b0, k});
    endfunction

    function automatic logic signed [47:0] ext48(input logic signed [31:0] v);
        return 48'(v);
    endfunction

endpackage

// ===== rtl/backstepping_trajectory_tracker.sv =====
// Backstepping unicycle trajectory tracker, Q16.16 fixed point, 16-stage pipeline.
// Throughput: one item per cycle; busy is always low, the pipeline never stalls.
// The receiver cannot stall: each result is shown for the single cycle of done.
// Reset (rst_n, async, active low) clears the valid bits and sets all gains to 1.0.
module backstepping_trajectory_tracker
    import bt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Values that ride alongside the sine/cosine pipeline
    typedef struct packed {
        logic signed [31:0] cv;
        logic signed [31:0] cw;
        logic signed [31:0] rv;
        logic signed [31:0] rw;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] de3;
    } dly_t;

    // Stage 9: first products
    typedef struct packed {
        logic signed [31:0] dxc;
        logic signed [31:0] dys;
        logic signed [31:0] dxs;
        logic signed [31:0] dyc;
        logic signed [31:0] rvc3;
        logic signed [31:0] rvs3;
        logic signed [31:0] k2v;
        logic signed [31:0] k3v;
        logic signed [31:0] s3;
        logic signed [31:0] c3;
        logic signed [31:0] de3;
        logic signed [31:0] cv;
        logic signed [31:0] cw;
        logic signed [31:0] rw;
    } s9_t;

    // Stage 10: robot-frame errors
    typedef struct packed {
        logic signed [31:0] e1;
        logic signed [31:0] e2;
        logic signed [31:0] ma;
        logic signed [31:0] k3vc3;
        logic signed [31:0] k3vs3;
        logic signed [31:0] rvc3;
        logic signed [31:0] rvs3;
        logic signed [31:0] k2v;
        logic signed [31:0] de3;
        logic signed [31:0] cv;
        logic signed [31:0] cw;
        logic signed [31:0] rw;
    } s10_t;

    // Stage 11: products with the errors
    typedef struct packed {
        logic signed [31:0] cwe2;
        logic signed [31:0] cwe1;
        logic signed [31:0] k1e1;
        logic signed [31:0] k2ve2;
        logic signed [31:0] mb;
        logic signed [31:0] ma;
        logic signed [31:0] rvc3;
        logic signed [31:0] rvs3;
        logic signed [31:0] k3vs3;
        logic signed [31:0] k2v;
        logic signed [31:0] cv;
        logic signed [31:0] cw;
        logic signed [31:0] rw;
    } s11_t;

    // Stage 12: error derivatives and auxiliary velocity
    typedef struct packed {
        logic signed [31:0] de1;
        logic signed [31:0] de2;
        logic signed [31:0] vcv;
        logic signed [31:0] vcw;
        logic signed [31:0] ma;
        logic signed [31:0] mb;
        logic signed [31:0] k2v;
        logic signed [31:0] cv;
        logic signed [31:0] cw;
    } s12_t;

    // Stage 13: velocity errors and derivative products
    typedef struct packed {
        logic signed [31:0] k1de1;
        logic signed [31:0] k2vde2;
        logic signed [31:0] ev;
        logic signed [31:0] ew;
        logic signed [31:0] ma;
        logic signed [31:0] mb;
    } s13_t;

    // Stage 14: auxiliary velocity derivative and feedback terms
    typedef struct packed {
        logic signed [31:0] dvv;
        logic signed [31:0] dvw;
        logic signed [31:0] k4ev;
        logic signed [31:0] k4ew;
    } s14_t;

    gains_t             gains;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;

    cmd_t               in_reg;
    dly_t               s1_next;
    logic signed [31:0] e3_reg;
    logic signed [31:0] e3_next;
    logic signed [31:0] head_reg;
    logic signed [31:0] head_next;
    dly_t               dly_reg [SC_LAT:0];

    logic signed [31:0] sh;
    logic signed [31:0] chd;
    logic signed [31:0] s3;
    logic signed [31:0] c3;

    s9_t                s9_reg;
    s9_t                s9_next;
    s10_t               s10_reg;
    s10_t               s10_next;
    s11_t               s11_reg;
    s11_t               s11_next;
    s12_t               s12_reg;
    s12_t               s12_next;
    s13_t               s13_reg;
    s13_t               s13_next;
    s14_t               s14_reg;
    s14_t               s14_next;
    result_t            result_reg;
    result_t            result_next;

    bt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .gains     (gains)
    );

    // Heading of the robot and heading error both enter from stage 1 registers,
    // so their sine/cosine come out in the same cycle
    bt_sincos u_sc_head (
        .clk   (clk),
        .angle (head_reg),
        .sin_q (sh),
        .cos_q (chd)
    );

    bt_sincos u_sc_err (
        .clk   (clk),
        .angle (e3_reg),
        .sin_q (s3),
        .cos_q (c3)
    );

    // Never stalls: a new item may start every cycle
    assign busy = 1'b0;

    // Valid bits shift with the data
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], start & ~busy};

    // Stage 1: position, heading and angular speed differences, from the input register
    always_comb
    begin
        s1_next.cv  = in_reg.cur_lin_speed;
        s1_next.cw  = in_reg.cur_ang_speed;
        s1_next.rv  = in_reg.ref_lin_speed;
        s1_next.rw  = in_reg.ref_ang_speed;
        s1_next.dx  = sat32(ext48(in_reg.ref_x) - ext48(in_reg.cur_x));
        s1_next.dy  = sat32(ext48(in_reg.ref_y) - ext48(in_reg.cur_y));
        s1_next.de3 = sat32(ext48(in_reg.ref_ang_speed) - ext48(in_reg.cur_ang_speed));
        e3_next     = sat32(ext48(in_reg.ref_heading) - ext48(in_reg.cur_heading));
        head_next   = in_reg.cur_heading;
    end

    // Stage 9: rotation products and speed-scaled gains
    always_comb
    begin
        s9_next.dxc  = qmul(dly_reg[SC_LAT].dx, chd);
        s9_next.dys  = qmul(dly_reg[SC_LAT].dy, sh);
        s9_next.dxs  = qmul(dly_reg[SC_LAT].dx, sh);
        s9_next.dyc  = qmul(dly_reg[SC_LAT].dy, chd);
        s9_next.rvc3 = qmul(dly_reg[SC_LAT].rv, c3);
        s9_next.rvs3 = qmul(dly_reg[SC_LAT].rv, s3);
        s9_next.k2v  = qmul(gain_q(gains.k2), dly_reg[SC_LAT].rv);
        s9_next.k3v  = qmul(gain_q(gains.k3), dly_reg[SC_LAT].rv);
        s9_next.s3   = s3;
        s9_next.c3   = c3;
        s9_next.de3  = dly_reg[SC_LAT].de3;
        s9_next.cv   = dly_reg[SC_LAT].cv;
        s9_next.cw   = dly_reg[SC_LAT].cw;
        s9_next.rw   = dly_reg[SC_LAT].rw;
    end

    // Stage 10: e1, e2 in the robot frame
    always_comb
    begin
        s10_next.e1    = sat32(ext48(s9_reg.dxc) + ext48(s9_reg.dys));
        s10_next.e2    = sat32(ext48(s9_reg.dyc) - ext48(s9_reg.dxs));
        s10_next.ma    = qmul(s9_reg.rvs3, s9_reg.de3);
        s10_next.k3vc3 = qmul(s9_reg.k3v, s9_reg.c3);
        s10_next.k3vs3 = qmul(s9_reg.k3v, s9_reg.s3);
        s10_next.rvc3  = s9_reg.rvc3;
        s10_next.rvs3  = s9_reg.rvs3;
        s10_next.k2v   = s9_reg.k2v;
        s10_next.de3   = s9_reg.de3;
        s10_next.cv    = s9_reg.cv;
        s10_next.cw    = s9_reg.cw;
        s10_next.rw    = s9_reg.rw;
    end

    // Stage 11
    always_comb
    begin
        s11_next.cwe2  = qmul(s10_reg.cw, s10_reg.e2);
        s11_next.cwe1  = qmul(s10_reg.cw, s10_reg.e1);
        s11_next.k1e1  = qmul(gain_q(gains.k1), s10_reg.e1);
        s11_next.k2ve2 = qmul(s10_reg.k2v, s10_reg.e2);
        s11_next.mb    = qmul(s10_reg.k3vc3, s10_reg.de3);
        s11_next.ma    = s10_reg.ma;
        s11_next.rvc3  = s10_reg.rvc3;
        s11_next.rvs3  = s10_reg.rvs3;
        s11_next.k3vs3 = s10_reg.k3vs3;
        s11_next.k2v   = s10_reg.k2v;
        s11_next.cv    = s10_reg.cv;
        s11_next.cw    = s10_reg.cw;
        s11_next.rw    = s10_reg.rw;
    end

    // Stage 12: three-term sums saturate once
    always_comb
    begin
        s12_next.de1 = sat32(ext48(s11_reg.cwe2) - ext48(s11_reg.cv) + ext48(s11_reg.rvc3));
        s12_next.de2 = sat32(ext48(s11_reg.rvs3) - ext48(s11_reg.cwe1));
        s12_next.vcv = sat32(ext48(s11_reg.rvc3) + ext48(s11_reg.k1e1));
        s12_next.vcw = sat32(ext48(s11_reg.rw) + ext48(s11_reg.k2ve2)
                             + ext48(s11_reg.k3vs3));
        s12_next.ma  = s11_reg.ma;
        s12_next.mb  = s11_reg.mb;
        s12_next.k2v = s11_reg.k2v;
        s12_next.cv  = s11_reg.cv;
        s12_next.cw  = s11_reg.cw;
    end

    // Stage 13
    always_comb
    begin
        s13_next.k1de1  = qmul(gain_q(gains.k1), s12_reg.de1);
        s13_next.k2vde2 = qmul(s12_reg.k2v, s12_reg.de2);
        s13_next.ev     = sat32(ext48(s12_reg.vcv) - ext48(s12_reg.cv));
        s13_next.ew     = sat32(ext48(s12_reg.vcw) - ext48(s12_reg.cw));
        s13_next.ma     = s12_reg.ma;
        s13_next.mb     = s12_reg.mb;
    end

    // Stage 14
    always_comb
    begin
        s14_next.dvv  = sat32(ext48(s13_reg.k1de1) - ext48(s13_reg.ma));
        s14_next.dvw  = sat32(ext48(s13_reg.k2vde2) + ext48(s13_reg.mb));
        s14_next.k4ev = qmul(gain_q(gains.k4), s13_reg.ev);
        s14_next.k4ew = qmul(gain_q(gains.k4), s13_reg.ew);
    end

    // Stage 15: drive commands
    always_comb
    begin
        result_next.lin_drive = sat32(ext48(s14_reg.dvv) + ext48(s14_reg.k4ev));
        result_next.ang_drive = sat32(ext48(s14_reg.dvw) + ext48(s14_reg.k4ew));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Payload registers need no reset
    always_ff @(posedge clk)
    begin
        in_reg     <= cmd;
        dly_reg[0] <= s1_next;
        e3_reg     <= e3_next;
        head_reg   <= head_next;
        for (int i = 1; i <= SC_LAT; i++)
            dly_reg[i] <= dly_reg[i-1];
        s9_reg     <= s9_next;
        s10_reg    <= s10_next;
        s11_reg    <= s11_next;
        s12_reg    <= s12_next;
        s13_reg    <= s13_next;
        s14_reg    <= s14_next;
        result_reg <= result_next;
    end

    assign done   = vld_reg[PIPE_DEPTH-1];
    assign result = result_reg;

endmodule

// ===== rtl/bt_cfg.sv =====
// Gain register file of the backstepping tracker.
// Depends on bt_pkg.
module bt_cfg
    import bt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        cfg_ready,
    output gains_t      gains
);

    gains_t gains_reg;
    gains_t gains_next;

    assign cfg_ready = 1'b1;
    assign gains     = gains_reg;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GAIN_LONG: gains_next.k1 = cfg_data[30:0];
                REG_GAIN_LAT:  gains_next.k2 = cfg_data[30:0];
                REG_GAIN_HEAD: gains_next.k3 = cfg_data[30:0];
                REG_GAIN_VEL:  gains_next.k4 = cfg_data[30:0];
                default:       gains_next = gains_reg; // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gains_reg <= '{k1: GAIN_RESET, k2: GAIN_RESET, k3: GAIN_RESET, k4: GAIN_RESET};
        else
            gains_reg <= gains_next;
    end

endmodule

// ===== rtl/bt_sincos.sv =====
// Pipelined sine/cosine of a Q16.16 angle in radians.
// Phase wrap, quarter-wave Horner polynomial, quadrant fold. Depends on bt_pkg.
module bt_sincos
    import bt_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] angle,
    output logic signed [31:0] sin_q,
    output logic signed [31:0] cos_q
);

    typedef struct packed {
        logic [1:0]         quad;
        logic [30:0]        xs;
        logic [30:0]        xc;
        logic [30:0]        x2s;
        logic [30:0]        x2c;
        logic signed [32:0] accs;
        logic signed [32:0] accc;
    } sc_stage_t;

    logic [31:0]        phase_reg;
    logic [31:0]        phase_next;
    sc_stage_t          st_reg [4:0];
    sc_stage_t          st_first;
    sc_stage_t          st_next [4:1];
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_next;
    logic signed [31:0] cos_next;

    function automatic logic signed [32:0] horner(input logic signed [32:0] acc,
                                                  input logic [30:0] x2,
                                                  input logic signed [32:0] coef);
        logic signed [63:0] p;
        p = 64'(acc) * 64'(signed'({1'b0, x2}));
        return coef + 33'(p >>> 30);
    endfunction

    function automatic logic [16:0] finish(input logic [30:0] x,
                                           input logic signed [32:0] acc);
        logic signed [63:0] p;
        logic signed [19:0] r;
        p = 64'(signed'({1'b0, x})) * 64'(acc);
        r = p[63:44];
        if (r < 0)
            r = '0;
        if (r > 20'sd65536)
            r = 20'sd65536;
        return r[16:0];
    endfunction

    always_comb
    begin
        logic signed [63:0] p;
        p = 64'(angle) * PHASE_SCALE;
        phase_next = p[47:16];
    end

    always_comb
    begin
        logic [61:0] sq_s;
        logic [61:0] sq_c;
        st_first      = '0;
        st_first.quad = phase_reg[31:30];
        st_first.xs   = {1'b0, phase_reg[29:0]};
        st_first.xc   = ONE_Q30 - {1'b0, phase_reg[29:0]};
        sq_s          = 62'(st_first.xs) * 62'(st_first.xs);
        sq_c          = 62'(st_first.xc) * 62'(st_first.xc);
        st_first.x2s  = sq_s[60:30];
        st_first.x2c  = sq_c[60:30];
        st_first.accs = PC9;
        st_first.accc = PC9;
    end

    // One Horner step per stage
    always_comb
    begin
        st_next[1]      = st_reg[0];
        st_next[1].accs = horner(st_reg[0].accs, st_reg[0].x2s, PC7);
        st_next[1].accc = horner(st_reg[0].accc, st_reg[0].x2c, PC7);
        st_next[2]      = st_reg[1];
        st_next[2].accs = horner(st_reg[1].accs, st_reg[1].x2s, PC5);
        st_next[2].accc = horner(st_reg[1].accc, st_reg[1].x2c, PC5);
        st_next[3]      = st_reg[2];
        st_next[3].accs = horner(st_reg[2].accs, st_reg[2].x2s, PC3);
        st_next[3].accc = horner(st_reg[2].accc, st_reg[2].x2c, PC3);
        st_next[4]      = st_reg[3];
        st_next[4].accs = horner(st_reg[3].accs, st_reg[3].x2s, PC1);
        st_next[4].accc = horner(st_reg[3].accc, st_reg[3].x2c, PC1);
    end

    always_comb
    begin
        logic [16:0] s;
        logic [16:0] c;
        s = finish(st_reg[4].xs, st_reg[4].accs);
        c = finish(st_reg[4].xc, st_reg[4].accc);
        unique case (st_reg[4].quad)
            2'd0:
            begin
                sin_next = 32'(s);
                cos_next = 32'(c);
            end
            2'd1:
            begin
                sin_next = 32'(c);
                cos_next = -32'(s);
            end
            2'd2:
            begin
                sin_next = -32'(s);
                cos_next = -32'(c);
            end
            default:
            begin
                sin_next = -32'(c);
                cos_next = 32'(s);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        st_reg[0] <= st_first;
        st_reg[1] <= st_next[1];
        st_reg[2] <= st_next[2];
        st_reg[3] <= st_next[3];
        st_reg[4] <= st_next[4];
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

// ===== rtl/bt_checker.sv =====
// Port-level checks on the backstepping tracker, attached by bind.
// Depends on bt_pkg and backstepping_trajectory_tracker.
module bt_checker
    import bt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_ready
);

    // Every accepted item comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(PIPE_DEPTH) done)
        else $error("item not delivered after pipeline latency");

    // No result appears without a matching accepted item
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_DEPTH))
        else $error("result without a matching item");

    // Neither channel ever pushes back
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("unexpected backpressure");

endmodule

bind backstepping_trajectory_tracker bt_checker u_bt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready)
);

// ===== verif/tb.sv =====
// Testbench for backstepping_trajectory_tracker: random and directed poses, checked
// against a Q16.16 model of the control law. Depends on rtl/bt_pkg.sv and the RTL top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    // ---------------------------------------------------------------
    // Control-law predictor, written in 64-bit arithmetic
    // ---------------------------------------------------------------
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return clamp32((a * b) >>> 16);
    endfunction

    // sin(pi*x/2), x in Q30 on [0, 2^30], result Q16 clamped to [0, 1.0]
    function automatic longint quarter_wave(longint x);
        longint x2, acc, r;
        x2 = (x * x) >>> 30;
        acc = 64'sd172272;
        acc = -64'sd5026993 + ((acc * x2) >>> 30);
        acc = 64'sd85569307 + ((acc * x2) >>> 30);
        acc = -64'sd693598667 + ((acc * x2) >>> 30);
        acc = 64'sd1686629713 + ((acc * x2) >>> 30);
        r = ((x * acc) >>> 30) >>> 14;
        if (r < 0) r = 0;
        if (r > 65536) r = 65536;
        return r;
    endfunction

    function automatic void angle_trig(input longint ang, output longint sn,
                                       output longint cs);
        logic [63:0] prod;
        logic [31:0] phase;
        longint f, s, c;
        prod = ang * 64'sd683565276;
        phase = prod[47:16];
        f = longint'(phase[29:0]);
        s = quarter_wave(f);
        c = quarter_wave(64'sd1073741824 - f);
        case (phase[31:30])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    function automatic result_t drive_law(cmd_t c, gains_t g);
        longint cx, cy, ch, cv, cw, rx, ry, rh, rv, rw, k1, k2, k3, k4;
        longint sh, chd, s3, c3, dx, dy, e1, e2, e3, de1, de2, de3;
        longint k2v, k3v, vcv, vcw, dvv, dvw;
        result_t r;
        cx = c.cur_x; cy = c.cur_y; ch = c.cur_heading;
        cv = c.cur_lin_speed; cw = c.cur_ang_speed;
        rx = c.ref_x; ry = c.ref_y; rh = c.ref_heading;
        rv = c.ref_lin_speed; rw = c.ref_ang_speed;
        k1 = g.k1; k2 = g.k2; k3 = g.k3; k4 = g.k4;
        angle_trig(ch, sh, chd);
        dx = clamp32(rx - cx);
        dy = clamp32(ry - cy);
        e1 = clamp32(fx_mul(dx, chd) + fx_mul(dy, sh));
        e2 = clamp32(-fx_mul(dx, sh) + fx_mul(dy, chd));
        e3 = clamp32(rh - ch);
        angle_trig(e3, s3, c3);
        de1 = clamp32(fx_mul(cw, e2) - cv + fx_mul(rv, c3));
        de2 = clamp32(-fx_mul(cw, e1) + fx_mul(rv, s3));
        de3 = clamp32(rw - cw);
        k2v = fx_mul(k2, rv);
        k3v = fx_mul(k3, rv);
        vcv = clamp32(fx_mul(rv, c3) + fx_mul(k1, e1));
        vcw = clamp32(rw + fx_mul(k2v, e2) + fx_mul(k3v, s3));
        dvv = clamp32(fx_mul(k1, de1) - fx_mul(fx_mul(rv, s3), de3));
        dvw = clamp32(fx_mul(k2v, de2) + fx_mul(fx_mul(k3v, c3), de3));
        r.lin_drive = 32'(clamp32(dvv + fx_mul(k4, clamp32(vcv - cv))));
        r.ang_drive = 32'(clamp32(dvw + fx_mul(k4, clamp32(vcw - cw))));
        return r;
    endfunction

    int error_count = 0;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        error_count++;
    endtask

    // Holds expected drive commands in order of acceptance
    class drive_scoreboard;
        result_t pending_drives[$];

        function void note_command(cmd_t c, gains_t g);
            pending_drives.push_back(drive_law(c, g));
        endfunction

        task check_drive(result_t got);
            result_t want;
            if (pending_drives.size() == 0)
            begin
                report_mismatch("drive command with none expected");
                return;
            end
            want = pending_drives.pop_front();
            if (got.lin_drive !== want.lin_drive)
                report_mismatch($sformatf("lin_drive got %h want %h",
                                          got.lin_drive, want.lin_drive));
            if (got.ang_drive !== want.ang_drive)
                report_mismatch($sformatf("ang_drive got %h want %h",
                                          got.ang_drive, want.ang_drive));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    cmd_t        cmd = '0;
    logic        done;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    backstepping_trajectory_tracker u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    drive_scoreboard board = new();
    gains_t active_gains = {4{GAIN_RESET}};
    int idle_cycles = 0;

    // Results can't be held off: sample every done strobe at the edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_drive(result);
    end

    // Watchdog on cycles with no accepted item, result or register write
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Register write; only called while the pipeline is drained.
    // The caller drops cfg_valid after the last write.
    task automatic write_gain(input logic [7:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_GAIN_LONG: active_gains.k1 = value[30:0];
            REG_GAIN_LAT:  active_gains.k2 = value[30:0];
            REG_GAIN_HEAD: active_gains.k3 = value[30:0];
            REG_GAIN_VEL:  active_gains.k4 = value[30:0];
            default: ;
        endcase
    endtask

    // Sends one item; a random gap comes first when allow_gap is set.
    // start stays high for back-to-back items; the caller drops it at the end.
    task automatic send_command(input cmd_t c, input bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(8) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (busy);
        board.note_command(c, active_gains);
    endtask

    task automatic drain;
        while (board.pending_drives.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // Mix of full-range values and modest Q16.16 magnitudes for realistic poses
    function automatic logic [31:0] pick_value();
        case ($urandom_range(4))
            0: return $urandom();
            1: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
        endcase
    endfunction

    function automatic cmd_t random_command();
        cmd_t c;
        logic [31:0] f [10];
        foreach (f[i]) f[i] = pick_value();
        c = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9]};
        return c;
    endfunction

    task automatic random_phase(input int count);
        bit burst;
        burst = $urandom_range(3) == 0;   // some phases run back to back
        repeat (count) send_command(random_command(), !burst);
        start <= 1'b0;
    endtask

    initial
    begin
        cmd_t c;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero error, extremes, quadrant boundaries of heading
        send_command('0, 1'b0);
        send_command({10{32'h7fffffff}}, 1'b0);
        send_command({10{32'h80000000}}, 1'b0);
        send_command({{5{32'h7fffffff}}, {5{32'h80000000}}}, 1'b0);
        send_command({{5{32'h80000000}}, {5{32'h7fffffff}}}, 1'b0);
        send_command({10{32'hffffffff}}, 1'b0);
        for (int q = 0; q < 8; q++)
        begin
            c = '0;
            c.cur_heading = 32'(q * 51472);          // steps of about pi/4
            c.ref_heading = -32'(q * 102944);
            c.ref_x = 32'sd65536;
            c.ref_lin_speed = 32'sd65536;
            c.ref_ang_speed = 32'sd32768;
            c.cur_lin_speed = 32'sd16384;
            send_command(c, 1'b0);
        end
        start <= 1'b0;
        drain();

        // Random phases under different gain settings, extremes included
        for (int phase = 0; phase < 6; phase++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                case (phase)
                    0: write_gain(8'(r), 32'h00010000);
                    1: write_gain(8'(r), 32'h00000000);
                    2: write_gain(8'(r), 32'hffffffff);
                    default: write_gain(8'(r), $urandom_range(3) == 0 ?
                                        $urandom() : $urandom_range(4 * 65536));
                endcase
            end
            if (phase == 3)
                write_gain(8'd9, $urandom());   // unknown index, ignored
            cfg_valid <= 1'b0;
            random_phase(80);
            drain();
        end

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/bt_pkg.sv
rtl/bt_cfg.sv
rtl/bt_sincos.sv
rtl/backstepping_trajectory_tracker.sv
rtl/bt_checker.sv
verif/tb.sv
